>>> sv/lbpms_pkg.sv
// Shared types and constants for the light bar pair match score block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lbpms_pkg;

	localparam int COORD_W = 16;
	localparam int CFG_W   = 16;
	localparam int TAG_W   = 6;

	localparam logic [15:0] DEG90  = 16'd23040;
	localparam logic [15:0] DEG180 = 16'd46080;

	// angle score 1280<<16 / (1280+d): first partial remainder is the dividend >> 17
	localparam logic [14:0] ANG_DIV   = 15'd1280;
	localparam logic [14:0] ANG_REM0  = 15'd640;
	// ratio score 2^28 / (4096+rd)
	localparam logic [29:0] RATIO_BASE = 30'd4096;
	localparam logic [29:0] RATIO_REM0 = 30'd2048;

	// x/10 == (x*DIV10_MUL) >> 24 for x < 2^22
	localparam logic [20:0] DIV10_MUL = 21'd1677722;

	typedef enum logic [2:0] {
		RSN_OK       = 3'd0,
		RSN_SHAPE    = 3'd1,
		RSN_PARALLEL = 3'd2,
		RSN_SIZE     = 3'd3,
		RSN_VERTICAL = 3'd4,
		RSN_ASPECT   = 3'd5
	} reason_t;

	typedef enum logic [2:0] {
		CFG_RATIO_MIN    = 3'd0,
		CFG_RATIO_MAX    = 3'd1,
		CFG_ANGLE_LIMIT  = 3'd2,
		CFG_SIZE_DIFF    = 3'd3,
		CFG_VERT_FACTOR  = 3'd4,
		CFG_ASPECT_MIN   = 3'd5,
		CFG_ASPECT_MAX   = 3'd6,
		CFG_ASPECT_IDEAL = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic             first_is_left;
		logic [TAG_W-1:0] first_tag;
		logic [TAG_W-1:0] second_tag;
	} echo_t;

endpackage

`default_nettype wire

>>> sv/lbpms_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Standalone; caller guarantees rem_init < den for a valid quotient.
`timescale 1ns / 1ps
`default_nettype none

module lbpms_div #(
	parameter int DEN_W = 16,
	parameter int Q_W   = 17
) (
	input  logic             clk,
	input  logic             en,
	input  logic [DEN_W-1:0] rem_init,
	input  logic [Q_W-1:0]   num,
	input  logic [DEN_W-1:0] den,
	output logic [Q_W-1:0]   quo
);

	logic [DEN_W-1:0] rem_s [1:Q_W-1];
	logic [DEN_W-1:0] den_s [1:Q_W-1];
	logic [Q_W-1:0]   num_s [1:Q_W-1];
	logic [Q_W-1:0]   quo_s [1:Q_W];

	genvar g;
	for (g = 1; g <= Q_W; g++) begin : g_step
		logic [DEN_W-1:0] rem_p;
		logic [DEN_W-1:0] den_p;
		logic [Q_W-1:0]   num_p;
		logic [Q_W-1:0]   quo_p;
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   diff;
		logic             take;

		if (g == 1) begin : g_first
			assign rem_p = rem_init;
			assign den_p = den;
			assign num_p = num;
			assign quo_p = '0;
		end else begin : g_next
			assign rem_p = rem_s[g-1];
			assign den_p = den_s[g-1];
			assign num_p = num_s[g-1];
			assign quo_p = quo_s[g-1];
		end

		assign trial = {rem_p, num_p[Q_W-1]};
		assign take  = trial >= {1'b0, den_p};
		assign diff  = take ? trial - {1'b0, den_p} : trial;

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[g] <= {quo_p[Q_W-2:0], take};
			end
		end

		if (g < Q_W) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g] <= diff[DEN_W-1:0];
					den_s[g] <= den_p;
					num_s[g] <= {num_p[Q_W-2:0], 1'b0};
				end
			end
		end
	end

	assign quo = quo_s[Q_W];

endmodule

`default_nettype wire

>>> sv/light_bar_pair_match_score.sv
// Light bar pair match score: pass/fail tests and confidence for two light bars.
// Depends on lbpms_pkg and lbpms_div.
`timescale 1ns / 1ps
`default_nettype none

// One pair is accepted every cycle unless the output beat is stalled, and its
// result beat leaves the last of 82 register stages. The pipe depth is set by the
// bit-serial square root of the squared center distance (29 stages), the divide of
// that root by the larger height (29 stages) and the ratio score divide (17 stages),
// all fully pipelined. While a result beat is stalled at the output the whole pipe
// holds and no pair is taken. The shape, parallel, size, vertical and aspect tests
// are exact; confidence is 0.3*size + 0.4*ratio + 0.3*angle in Q0.16, floored,
// saturated at 65535 and zero for a rejected pair. Configuration is written through
// cfg_wr_en / cfg_index / cfg_data; the user must do so only while the pipe is
// empty, which the block itself does not enforce.
module light_bar_pair_match_score (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,

	input  logic        pair_valid,
	output logic        pair_stall,
	input  logic [15:0] first_center_x,
	input  logic [15:0] first_center_y,
	input  logic [15:0] first_width,
	input  logic [15:0] first_height,
	input  logic signed [15:0] first_angle,
	input  logic [15:0] second_center_x,
	input  logic [15:0] second_center_y,
	input  logic [15:0] second_width,
	input  logic [15:0] second_height,
	input  logic signed [15:0] second_angle,
	input  logic [5:0]  first_tag,
	input  logic [5:0]  second_tag,

	output logic        score_valid,
	input  logic        score_stall,
	output logic        matched,
	output logic [2:0]  reject_reason,
	output logic        first_is_left,
	output logic [15:0] confidence,
	output logic [5:0]  pair_first_tag,
	output logic [5:0]  pair_second_tag
);

	localparam int LAST = 82;

	// config registers
	logic [15:0] ratio_min_q, ratio_max_q, size_diff_q, vert_factor_q;
	logic [15:0] aspect_min_q, aspect_max_q, aspect_ideal_q;
	logic [14:0] angle_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_min_q    <= 16'd6554;
			ratio_max_q    <= 16'd32768;
			angle_limit_q  <= 15'd1280;
			size_diff_q    <= 16'd32768;
			vert_factor_q  <= 16'd52429;
			aspect_min_q   <= 16'd3277;
			aspect_max_q   <= 16'd12288;
			aspect_ideal_q <= 16'd9830;
		end else if (cfg_wr_en) begin
			case (lbpms_pkg::cfg_idx_t'(cfg_index))
				lbpms_pkg::CFG_RATIO_MIN:    ratio_min_q    <= cfg_data;
				lbpms_pkg::CFG_RATIO_MAX:    ratio_max_q    <= cfg_data;
				lbpms_pkg::CFG_ANGLE_LIMIT:  angle_limit_q  <= cfg_data[14:0];
				lbpms_pkg::CFG_SIZE_DIFF:    size_diff_q    <= cfg_data;
				lbpms_pkg::CFG_VERT_FACTOR:  vert_factor_q  <= cfg_data;
				lbpms_pkg::CFG_ASPECT_MIN:   aspect_min_q   <= cfg_data;
				lbpms_pkg::CFG_ASPECT_MAX:   aspect_max_q   <= cfg_data;
				lbpms_pkg::CFG_ASPECT_IDEAL: aspect_ideal_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// flow control: whole pipe holds while the output beat is stalled
	logic vld_s [1:LAST];
	logic adv;

	assign adv        = !(vld_s[LAST] && score_stall);
	assign pair_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAST; i++) vld_s[i] <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= pair_valid;
			for (int i = 2; i <= LAST; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// stage 1: differences, maxima, folded angle
	logic [15:0] dh_c, mh_c, dw_c, mw_c, dx_c, dy_c;
	logic signed [16:0] adiff_c;
	logic [16:0] aabs_c;
	logic [15:0] ad_a_c, ad_f_c;

	assign dh_c = (first_height > second_height) ? first_height - second_height
	                                             : second_height - first_height;
	assign mh_c = (first_height > second_height) ? first_height : second_height;
	assign dw_c = (first_width > second_width) ? first_width - second_width
	                                           : second_width - first_width;
	assign mw_c = (first_width > second_width) ? first_width : second_width;
	assign dx_c = (first_center_x > second_center_x) ? first_center_x - second_center_x
	                                                 : second_center_x - first_center_x;
	assign dy_c = (first_center_y > second_center_y) ? first_center_y - second_center_y
	                                                 : second_center_y - first_center_y;

	assign adiff_c = {first_angle[15], first_angle} - {second_angle[15], second_angle};
	assign aabs_c  = adiff_c[16] ? 17'(-adiff_c) : 17'(adiff_c);
	assign ad_a_c  = (aabs_c[15:0] > lbpms_pkg::DEG180) ? aabs_c[15:0] - lbpms_pkg::DEG180
	                                                     : aabs_c[15:0];
	assign ad_f_c  = (ad_a_c > lbpms_pkg::DEG90) ? lbpms_pkg::DEG180 - ad_a_c : ad_a_c;

	logic [15:0] dh_s1, mh_s1, dw_s1, mw_s1, dx_s1, dy_s1;
	logic [15:0] w1_s1, h1_s1, w2_s1, h2_s1;
	logic [14:0] ad_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			dh_s1 <= dh_c;
			mh_s1 <= mh_c;
			dw_s1 <= dw_c;
			mw_s1 <= mw_c;
			dx_s1 <= dx_c;
			dy_s1 <= dy_c;
			ad_s1 <= ad_f_c[14:0];
			w1_s1 <= first_width;
			h1_s1 <= first_height;
			w2_s1 <= second_width;
			h2_s1 <= second_height;
		end
	end

	// stage 2: threshold products
	logic [31:0] pmax1_s2, pmin1_s2, pmax2_s2, pmin2_s2;
	logic [31:0] psh_s2, psw_s2, pv_s2, lo_s2, hi_s2, dx2_s2, dy2_s2;
	logic [15:0] w1_s2, w2_s2, dh_s2, dw_s2, dy_s2;
	logic        h1z_s2, h2z_s2, mwnz_s2, angfail_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			pmax1_s2   <= 32'(ratio_max_q) * 32'(h1_s1);
			pmin1_s2   <= 32'(ratio_min_q) * 32'(h1_s1);
			pmax2_s2   <= 32'(ratio_max_q) * 32'(h2_s1);
			pmin2_s2   <= 32'(ratio_min_q) * 32'(h2_s1);
			psh_s2     <= 32'(size_diff_q) * 32'(mh_s1);
			psw_s2     <= 32'(size_diff_q) * 32'(mw_s1);
			pv_s2      <= 32'(vert_factor_q) * 32'(mh_s1);
			lo_s2      <= 32'(aspect_min_q) * 32'(mh_s1);
			hi_s2      <= 32'(aspect_max_q) * 32'(mh_s1);
			dx2_s2     <= 32'(dx_s1) * 32'(dx_s1);
			dy2_s2     <= 32'(dy_s1) * 32'(dy_s1);
			w1_s2      <= w1_s1;
			w2_s2      <= w2_s1;
			dh_s2      <= dh_s1;
			dw_s2      <= dw_s1;
			dy_s2      <= dy_s1;
			h1z_s2     <= (h1_s1 == 16'd0);
			h2z_s2     <= (h2_s1 == 16'd0);
			mwnz_s2    <= (mw_s1 != 16'd0);
			angfail_s2 <= (ad_s1 >= angle_limit_q);
		end
	end

	// stage 3: first four tests, squared distance and squared aspect bounds
	logic shape_fail_c, size_fail_c, vert_fail_c;

	assign shape_fail_c = h1z_s2 || h2z_s2 ||
	                      ({w1_s2, 16'h0} > pmax1_s2) || ({w1_s2, 16'h0} < pmin1_s2) ||
	                      ({w2_s2, 16'h0} > pmax2_s2) || ({w2_s2, 16'h0} < pmin2_s2);
	assign size_fail_c  = ({dh_s2, 16'h0} > psh_s2) ||
	                      (mwnz_s2 && ({dw_s2, 16'h0} > psw_s2));
	assign vert_fail_c  = ({dy_s2, 16'h0} > pv_s2);

	lbpms_pkg::reason_t reason_s3;
	logic        pend_s3;
	logic [32:0] d2_s3;
	logic [63:0] lo2_s3, hi2_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			pend_s3 <= !(shape_fail_c || angfail_s2 || size_fail_c || vert_fail_c);
			if (shape_fail_c)
				reason_s3 <= lbpms_pkg::RSN_SHAPE;
			else if (angfail_s2)
				reason_s3 <= lbpms_pkg::RSN_PARALLEL;
			else if (size_fail_c)
				reason_s3 <= lbpms_pkg::RSN_SIZE;
			else if (vert_fail_c)
				reason_s3 <= lbpms_pkg::RSN_VERTICAL;
			else
				reason_s3 <= lbpms_pkg::RSN_OK;
			d2_s3  <= 33'(dx2_s2) + 33'(dy2_s2);
			lo2_s3 <= 64'(lo_s2) * 64'(lo_s2);
			hi2_s3 <= 64'(hi_s2) * 64'(hi_s2);
		end
	end

	// stage 4: aspect test
	logic [63:0] ds_c;
	logic        asp_fail_c;
	lbpms_pkg::reason_t reason_c;

	assign ds_c       = {7'd0, d2_s3, 24'd0};
	assign asp_fail_c = (ds_c < lo2_s3) || (ds_c > hi2_s3);
	assign reason_c   = !pend_s3 ? reason_s3 :
	                    asp_fail_c ? lbpms_pkg::RSN_ASPECT : lbpms_pkg::RSN_OK;

	// delay lines
	lbpms_pkg::reason_t reason_s [4:LAST-1];
	lbpms_pkg::echo_t   echo_s [1:LAST-1];
	logic [15:0] mh_s [2:32];
	logic        mwnz_s [2:18];
	logic [16:0] ss_s [19:79];
	logic [16:0] sa_s [19:79];
	logic [16:0] l1_q18, l2_q18, sa_q18, sr_q79;
	logic [28:0] r_q61;
	logic [16:0] l2m_c;

	assign l2m_c = mwnz_s[18] ? l2_q18 : 17'd0;

	always_ff @(posedge clk) begin
		if (adv) begin
			echo_s[1] <= '{first_is_left: (first_center_x < second_center_x),
			               first_tag: first_tag, second_tag: second_tag};
			for (int i = 2; i <= LAST-1; i++) echo_s[i] <= echo_s[i-1];
			reason_s[4] <= reason_c;
			for (int i = 5; i <= LAST-1; i++) reason_s[i] <= reason_s[i-1];
			mh_s[2] <= mh_s1;
			for (int i = 3; i <= 32; i++) mh_s[i] <= mh_s[i-1];
			mwnz_s[2] <= (mw_s1 != 16'd0);
			for (int i = 3; i <= 18; i++) mwnz_s[i] <= mwnz_s[i-1];
			ss_s[19] <= 17'((34'(17'h10000 - l1_q18) * 34'(17'h10000 - l2m_c)) >> 16);
			for (int i = 20; i <= 79; i++) ss_s[i] <= ss_s[i-1];
			sa_s[19] <= sa_q18;
			for (int i = 20; i <= 79; i++) sa_s[i] <= sa_s[i-1];
		end
	end

	// size and angle score dividers, stages 2..18
	lbpms_div #(.DEN_W(16), .Q_W(17)) u_div_l1 (
		.clk(clk), .en(adv),
		.rem_init({1'b0, dh_s1[15:1]}), .num({dh_s1[0], 16'h0}), .den(mh_s1),
		.quo(l1_q18)
	);

	lbpms_div #(.DEN_W(16), .Q_W(17)) u_div_l2 (
		.clk(clk), .en(adv),
		.rem_init({1'b0, dw_s1[15:1]}), .num({dw_s1[0], 16'h0}), .den(mw_s1),
		.quo(l2_q18)
	);

	lbpms_div #(.DEN_W(15), .Q_W(17)) u_div_ang (
		.clk(clk), .en(adv),
		.rem_init(lbpms_pkg::ANG_REM0), .num(17'd0), .den(lbpms_pkg::ANG_DIV + ad_s1),
		.quo(sa_q18)
	);

	// integer square root of d2 << 24, stages 4..32
	logic [30:0] sq_rem_s  [4:31];
	logic [57:0] sq_v_s    [4:31];
	logic [28:0] sq_root_s [4:32];

	genvar g;
	for (g = 4; g <= 32; g++) begin : g_sqrt
		logic [30:0] rem_p;
		logic [57:0] v_p;
		logic [28:0] root_p;
		logic [30:0] cur, trial;
		logic        take;

		if (g == 4) begin : g_first
			assign rem_p  = '0;
			assign v_p    = {1'b0, d2_s3, 24'd0};
			assign root_p = '0;
		end else begin : g_next
			assign rem_p  = sq_rem_s[g-1];
			assign v_p    = sq_v_s[g-1];
			assign root_p = sq_root_s[g-1];
		end

		assign cur   = {rem_p[28:0], v_p[57:56]};
		assign trial = {root_p, 2'b01};
		assign take  = cur >= trial;

		always_ff @(posedge clk) begin
			if (adv) sq_root_s[g] <= {root_p[27:0], take};
		end

		if (g < 32) begin : g_carry
			always_ff @(posedge clk) begin
				if (adv) begin
					sq_rem_s[g] <= take ? cur - trial : cur;
					sq_v_s[g]   <= {v_p[55:0], 2'b00};
				end
			end
		end
	end

	// aspect r = root / max height, stages 33..61
	lbpms_div #(.DEN_W(16), .Q_W(29)) u_div_r (
		.clk(clk), .en(adv),
		.rem_init(16'd0), .num(sq_root_s[32]), .den(mh_s[32]),
		.quo(r_q61)
	);

	// stage 62: distance from ideal aspect
	logic [29:0] rden_s62;
	logic [28:0] ideal_c, rd_c;

	assign ideal_c = 29'(aspect_ideal_q);
	assign rd_c    = (r_q61 > ideal_c) ? r_q61 - ideal_c : ideal_c - r_q61;

	always_ff @(posedge clk) begin
		if (adv) rden_s62 <= 30'(rd_c) + lbpms_pkg::RATIO_BASE;
	end

	// ratio score, stages 63..79
	lbpms_div #(.DEN_W(30), .Q_W(17)) u_div_ratio (
		.clk(clk), .en(adv),
		.rem_init(lbpms_pkg::RATIO_REM0), .num(17'd0), .den(rden_s62),
		.quo(sr_q79)
	);

	// stages 80..82: weighted sum, divide by ten, saturate
	logic [19:0] sum_s80;
	logic [40:0] prod_s81;
	logic [16:0] conf_c;
	logic        matched_s82, left_s82;
	logic [2:0]  reason_s82;
	logic [15:0] conf_s82;
	logic [5:0]  tag1_s82, tag2_s82;

	assign conf_c = prod_s81[40:24];

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s80  <= 20'(ss_s[79]) * 20'd3 + 20'(sr_q79) * 20'd4 + 20'(sa_s[79]) * 20'd3;
			prod_s81 <= 41'(sum_s80) * 41'(lbpms_pkg::DIV10_MUL);
			matched_s82 <= (reason_s[81] == lbpms_pkg::RSN_OK);
			reason_s82  <= reason_s[81];
			left_s82    <= echo_s[81].first_is_left;
			tag1_s82    <= echo_s[81].first_tag;
			tag2_s82    <= echo_s[81].second_tag;
			if (reason_s[81] != lbpms_pkg::RSN_OK)
				conf_s82 <= 16'd0;
			else if (conf_c[16])
				conf_s82 <= 16'hFFFF;
			else
				conf_s82 <= conf_c[15:0];
		end
	end

	assign score_valid     = vld_s[LAST];
	assign matched         = matched_s82;
	assign reject_reason   = reason_s82;
	assign first_is_left   = left_s82;
	assign confidence      = conf_s82;
	assign pair_first_tag  = tag1_s82;
	assign pair_second_tag = tag2_s82;

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(score_valid && !matched) |->
			(confidence == 16'd0 && reject_reason != lbpms_pkg::RSN_OK))
		else $error("rejected beat with nonzero confidence or ok reason");

	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		(score_valid && score_stall) |-> pair_stall)
		else $error("input taken while output beat stalled");

	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[80] && reason_s[80] == lbpms_pkg::RSN_OK) |-> (sum_s80 <= 20'd655360))
		else $error("weighted score sum out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[LAST-1] && !adv) |=> vld_s[LAST-1])
		else $error("beat lost in pipe during stall");

endmodule

`default_nettype wire
